/* hw/rtl/mlr_pkg.sv */
// Shared types and constants for the midpoint line rasterizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mlr_pkg;

    localparam int COORD_BITS = 12;
    // Decision term and its increments: signed, with headroom for 2*delta.
    localparam int DEC_BITS   = COORD_BITS + 4;

    typedef logic [COORD_BITS-1:0]       coord_t;
    typedef logic signed [DEC_BITS-1:0]  dec_t;

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t   command;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } line_cmd_t;

    typedef struct packed
    {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last;
    } pixel_t;

endpackage

/* hw/rtl/midpoint_line_rasterizer_core.sv */
// Top level of the midpoint line rasterizer: input register, engine, output register.
// Depends on mlr_pkg, mlr_in_stage, mlr_engine and mlr_out_stage.
`timescale 1ns / 1ps

// Midpoint (Bresenham) line rasterizer. Send a start command (tuser = 0)
// with two endpoints in tdata; the block answers with the first pixel of
// the line, ordered so that the major coordinate rises. Each step command
// (tuser = 1) answers with the next pixel; tlast marks the final pixel of
// the line. A step while no line is in progress is consumed and gives no
// output; a start while a line is in progress abandons it. Every command
// sits in the input register while the engine works on it combinationally,
// and its pixel is loaded into the output register when that register is
// empty or its pixel is taken; it then appears on the pixel channel. The
// block sustains one command and one pixel per clock while the output is
// not stalled: the per-pixel update is combinational in the engine between
// the two registers. Backpressure on the output stalls the pipeline from
// the output register backward through tready.
module midpoint_line_rasterizer_core
    import mlr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Command channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata, low bit up: x_start, y_start, x_end, y_end
    input  logic [4*COORD_BITS-1:0] s_tdata,
    // tuser: command (0 = start, 1 = step)
    input  logic                  s_tuser,
    // Pixel channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata, low bit up: pixel_x, pixel_y
    output logic [2*COORD_BITS-1:0] m_tdata,
    // tlast: final pixel of the line
    output logic                  m_tlast
);

    line_cmd_t in_cmd;
    line_cmd_t cmd;
    logic      cmd_valid;
    logic      advance;
    logic      res_valid;
    pixel_t    res;
    pixel_t    out_pix;
    logic      eng_active;

    // Unpack the command transaction.
    assign in_cmd.command = cmd_t'(s_tuser);
    assign in_cmd.x_start = s_tdata[COORD_BITS-1:0];
    assign in_cmd.y_start = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_cmd.x_end   = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_cmd.y_end   = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    mlr_in_stage u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .advance   (advance),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // Hold line state; advance it once per command that moves on.
    mlr_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .active    (eng_active)
    );

    mlr_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix)
    );

    // Pack the pixel transaction.
    assign m_tdata = {out_pix.pixel_y, out_pix.pixel_x};
    assign m_tlast = out_pix.last;

    // A step with no line in progress must not produce a pixel.
    a_idle_step_drops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && advance && (cmd.command == CMD_STEP) && !eng_active
        |=> !m_tvalid)
    else $error("idle step produced a pixel");

    // A start always produces its first pixel.
    a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && advance && (cmd.command == CMD_START)
        |=> m_tvalid)
    else $error("start produced no pixel");

    // A freshly loaded final pixel leaves no line in progress.
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid && res.last
        |=> m_tvalid && m_tlast && !eng_active)
    else $error("line still active after final pixel");

    // A stalled command stays put in the input register.
    a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !advance
        |=> cmd_valid && $stable(cmd))
    else $error("stalled command lost or changed");

endmodule

/* hw/rtl/mlr_in_stage.sv */
// Input register of the line rasterizer: holds one command transaction.
// Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_in_stage
    import mlr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  line_cmd_t in_cmd,
    input  logic      advance,
    output logic      cmd_valid,
    output line_cmd_t cmd
);

    logic      valid_reg;
    logic      valid_next;
    line_cmd_t cmd_reg;

    // Take a new command when empty or when the held one moves on.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= in_cmd;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

/* hw/rtl/mlr_engine.sv */
// Line state and one-step midpoint update: setup on start, one pixel per step.
// Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_engine
    import mlr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  line_cmd_t cmd,
    input  logic      advance,
    output logic      res_valid,
    output pixel_t    res,
    output logic      active
);

    localparam int DPAD = DEC_BITS - COORD_BITS;

    logic   active_reg,   active_next;
    logic   y_major_reg,  y_major_next;
    logic   minor_up_reg, minor_up_next;
    coord_t cur_x_reg,    cur_x_next;
    coord_t cur_y_reg,    cur_y_next;
    coord_t major_end_reg, major_end_next;
    dec_t   decision_reg, decision_next;
    dec_t   inc_take_reg, inc_take_next;
    dec_t   inc_keep_reg, inc_keep_next;

    // Setup path
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]        adx_w, ady_w;
    coord_t                     adx, ady, dmaj, amin;
    logic                       x_major, swap, minor_neg;
    dec_t                       dmaj_ext, amin2_ext;

    // Step path
    coord_t maj, mnr, maj_step, mnr_step;
    logic   take;

    logic fire;
    logic is_start;

    assign fire     = cmd_valid && advance;
    assign is_start = (cmd.command == CMD_START);

    always_comb
    begin
        dx = $signed({1'b0, cmd.x_end}) - $signed({1'b0, cmd.x_start});
        dy = $signed({1'b0, cmd.y_end}) - $signed({1'b0, cmd.y_start});
        adx_w = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
        ady_w = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
        adx = adx_w[COORD_BITS-1:0];
        ady = ady_w[COORD_BITS-1:0];
        // Ties go to x as the major axis.
        x_major   = (ady <= adx);
        swap      = x_major ? dx[COORD_BITS] : dy[COORD_BITS];
        minor_neg = x_major ? dy[COORD_BITS] : dx[COORD_BITS];
        dmaj      = x_major ? adx : ady;
        amin      = x_major ? ady : adx;
        dmaj_ext  = $signed({{DPAD{1'b0}}, dmaj});
        amin2_ext = $signed({{(DPAD-1){1'b0}}, amin, 1'b0});

        maj      = y_major_reg ? cur_y_reg : cur_x_reg;
        mnr      = y_major_reg ? cur_x_reg : cur_y_reg;
        take     = decision_reg[DEC_BITS-1] || (decision_reg == '0);
        maj_step = maj + 1'b1;
        mnr_step = take ? (minor_up_reg ? mnr + 1'b1 : mnr - 1'b1) : mnr;

        active_next    = active_reg;
        y_major_next   = y_major_reg;
        minor_up_next  = minor_up_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        major_end_next = major_end_reg;
        decision_next  = decision_reg;
        inc_take_next  = inc_take_reg;
        inc_keep_next  = inc_keep_reg;

        if (is_start)
        begin
            y_major_next   = !x_major;
            cur_x_next     = swap ? cmd.x_end : cmd.x_start;
            cur_y_next     = swap ? cmd.y_end : cmd.y_start;
            major_end_next = x_major ? (swap ? cmd.x_start : cmd.x_end)
                                     : (swap ? cmd.y_start : cmd.y_end);
            // Minor rises when its delta is positive after the swap.
            minor_up_next  = (amin != '0) && (swap ? minor_neg : !minor_neg);
            decision_next  = dmaj_ext - amin2_ext;
            inc_take_next  = (dmaj_ext <<< 1) - amin2_ext;
            inc_keep_next  = -amin2_ext;
            active_next    = (dmaj != '0);
        end
        else if (active_reg)
        begin
            decision_next = decision_reg + (take ? inc_take_reg : inc_keep_reg);
            if (y_major_reg)
            begin
                cur_y_next = maj_step;
                cur_x_next = mnr_step;
            end
            else
            begin
                cur_x_next = maj_step;
                cur_y_next = mnr_step;
            end
            active_next = (maj_step != major_end_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            y_major_reg  <= 1'b0;
            minor_up_reg <= 1'b0;
        end
        else if (fire)
        begin
            active_reg   <= active_next;
            y_major_reg  <= y_major_next;
            minor_up_reg <= minor_up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            major_end_reg <= major_end_next;
            decision_reg  <= decision_next;
            inc_take_reg  <= inc_take_next;
            inc_keep_reg  <= inc_keep_next;
        end
    end

    // A step with no line in progress yields nothing.
    assign res_valid   = cmd_valid && (is_start || active_reg);
    assign res.pixel_x = cur_x_next;
    assign res.pixel_y = cur_y_next;
    assign res.last    = !active_next;
    assign active      = active_reg;

endmodule

/* hw/rtl/mlr_out_stage.sv */
// Output register of the line rasterizer: holds one pixel until taken.
// Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_out_stage
    import mlr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   res_valid,
    input  pixel_t res,
    output logic   advance,
    output logic   out_valid,
    input  logic   out_ready,
    output pixel_t out_pix
);

    logic   valid_reg;
    logic   valid_next;
    pixel_t pix_reg;

    // Load a new result when empty or when the held pixel is taken.
    assign advance    = !valid_reg || out_ready;
    assign valid_next = advance ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            pix_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule
